// ===== rtl/dvru_pkg.sv =====
// Shared types and constants for the distance-vector route update unit.
// No dependencies; imported by distance_vector_route_update_unit and dvru_engine.
package dvru_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int SLOT_W      = $clog2(TABLE_DEPTH);
   localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);

   localparam int REQ_DATA_W  = 56;
   localparam int REQ_USER_W  = 1;
   localparam int RSP_DATA_W  = 32;
   localparam int RSP_USER_W  = 3;

   typedef enum logic [0:0] {
      OP_LOAD   = 1'b0,
      OP_ADVERT = 1'b1
   } opcode_type;

   typedef enum logic [2:0] {
      STAT_ADDED     = 3'd0,
      STAT_REFRESHED = 3'd1,
      STAT_REROUTED  = 3'd2,
      STAT_KEPT      = 3'd3,
      STAT_DUPLICATE = 3'd4,
      STAT_FULL      = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_DECIDE
   } state_type;

   typedef struct packed {
      opcode_type  opcode;
      logic [31:0] net_id;
      logic [7:0]  distance;
      logic [15:0] router_id;
   } req_item_type;

   typedef struct packed {
      status_type  status;
      logic [5:0]  slot;
      logic [7:0]  route_distance;
      logic [15:0] route_next_hop;
   } rsp_item_type;

   // one table row as held in the RAM
   typedef struct packed {
      logic [31:0] net;
      logic [7:0]  distance;
      logic [15:0] next_hop;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic start;
      logic out_free;
   } engine_ctrl_type;

   typedef struct packed {
      logic idle;
      logic done;
   } engine_stat_type;

endpackage

// ===== rtl/distance_vector_route_update_unit.sv =====
// Route table update unit: a 64-entry table searched one slot per cycle.
// A request is answered after a scan of the used slots (up to the fill count) through
// the single-read-port RAM; an item is taken only when the previous one is done.
// Reset (synchronous, active high) empties the table by clearing the fill count.
// Depends on dvru_pkg and dvru_engine.
module distance_vector_route_update_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // [31:0] net_id, [39:32] distance, [55:40] router_id
   input  logic [dvru_pkg::REQ_DATA_W-1:0]  req_tdata,
   // [0] opcode
   input  logic [dvru_pkg::REQ_USER_W-1:0]  req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [5:0] slot, [13:6] route_distance, [29:14] route_next_hop, [31:30] zero
   output logic [dvru_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // [2:0] status
   output logic [dvru_pkg::RSP_USER_W-1:0]  rsp_tuser
);
   import dvru_pkg::*;

   engine_ctrl_type ctrl;
   engine_stat_type stat;
   req_item_type    req_item;
   rsp_item_type    eng_rsp;

   logic            rsp_valid_ff, rsp_valid_in;
   rsp_item_type    rsp_item_ff, rsp_item_in;

   assign req_item.opcode    = opcode_type'(req_tuser[0]);
   assign req_item.net_id    = req_tdata[31:0];
   assign req_item.distance  = req_tdata[39:32];
   assign req_item.router_id = req_tdata[55:40];

   assign req_tready    = stat.idle;
   assign ctrl.start    = req_tvalid & stat.idle;
   assign ctrl.out_free = ~rsp_valid_ff | rsp_tready;

   dvru_engine u_engine (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (ctrl),
      .req_item (req_item),
      .stat     (stat),
      .rsp_item (eng_rsp)
   );

   // response holding register; engine only finishes when it is free
   always_comb begin
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_item_in  = rsp_item_ff;
      if (stat.done) begin
         rsp_valid_in = 1'b1;
         rsp_item_in  = eng_rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_item_ff.status;
   assign rsp_tdata  = {2'b00, rsp_item_ff.route_next_hop,
                        rsp_item_ff.route_distance, rsp_item_ff.slot};

endmodule

// ===== rtl/dvru_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module dvru_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/dvru_engine.sv =====
// Search and update sequencer for the route table.
// Depends on dvru_pkg and dvru_ram (table storage).
module dvru_engine (
   input  logic                     clock,
   input  logic                     reset,
   input  dvru_pkg::engine_ctrl_type ctrl,
   input  dvru_pkg::req_item_type   req_item,
   output dvru_pkg::engine_stat_type stat,
   output dvru_pkg::rsp_item_type   rsp_item
);
   import dvru_pkg::*;

   state_type          state_ff, state_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [COUNT_W-1:0] idx_ff, idx_in;
   logic [SLOT_W-1:0]  cmp_ff, cmp_in;
   logic               found_ff, found_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   entry_type          hit_ff, hit_in;
   req_item_type       item_ff, item_in;

   logic               rd_en;
   logic [SLOT_W-1:0]  rd_addr;
   logic [ENTRY_W-1:0] rd_raw;
   entry_type          rd_entry;
   logic               wr_en;
   logic [SLOT_W-1:0]  wr_addr;
   entry_type          wr_entry;
   logic               match;
   logic               table_full;
   logic [SLOT_W+5:0]  slot_ext;
   logic [7:0]         adj_dist;

   dvru_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   assign rd_entry   = entry_type'(rd_raw);
   assign match      = (rd_entry.net == item_ff.net_id);
   assign table_full = (count_ff == COUNT_W'(TABLE_DEPTH));

   // advertised distance gains one hop, saturating
   always_comb begin
      if (req_item.opcode == OP_ADVERT && req_item.distance != 8'hFF) begin
         adj_dist = req_item.distance + 8'd1;
      end else begin
         adj_dist = req_item.distance;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      idx_ff   <= idx_in;
      cmp_ff   <= cmp_in;
      found_ff <= found_in;
      slot_ff  <= slot_in;
      hit_ff   <= hit_in;
      item_ff  <= item_in;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (ctrl.start) begin
               state_in = (count_ff == '0) ? S_DECIDE : S_SCAN;
            end
         end
         S_SCAN: begin
            if (match || idx_ff == count_ff) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (ctrl.out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      count_in  = count_ff;
      idx_in    = idx_ff;
      cmp_in    = cmp_ff;
      found_in  = found_ff;
      slot_in   = slot_ff;
      hit_in    = hit_ff;
      item_in   = item_ff;
      rd_en     = 1'b0;
      rd_addr   = idx_ff[SLOT_W-1:0];
      wr_en     = 1'b0;
      wr_addr   = slot_ff;
      wr_entry  = hit_ff;
      stat.idle = 1'b0;
      stat.done = 1'b0;
      rsp_item  = '0;
      slot_ext  = {6'd0, slot_ff};

      case (state_ff)
         S_IDLE: begin
            stat.idle = 1'b1;
            if (ctrl.start) begin
               item_in          = req_item;
               item_in.distance = adj_dist;
               found_in         = 1'b0;
               // first read goes out with the accept
               rd_en            = 1'b1;
               rd_addr          = '0;
               cmp_in           = '0;
               idx_in           = COUNT_W'(1);
            end
         end
         S_SCAN: begin
            // rd_entry holds slot cmp_ff; idx_ff is the next slot to fetch
            if (match) begin
               found_in = 1'b1;
               slot_in  = cmp_ff;
               hit_in   = rd_entry;
            end else if (idx_ff != count_ff) begin
               rd_en  = 1'b1;
               cmp_in = idx_ff[SLOT_W-1:0];
               idx_in = idx_ff + COUNT_W'(1);
            end
         end
         S_DECIDE: begin
            if (!found_ff) begin
               if (table_full) begin
                  rsp_item.status = STAT_FULL;
               end else begin
                  slot_ext                = {6'd0, count_ff[SLOT_W-1:0]};
                  wr_en                   = ctrl.out_free;
                  wr_addr                 = count_ff[SLOT_W-1:0];
                  wr_entry.net            = item_ff.net_id;
                  wr_entry.distance       = item_ff.distance;
                  wr_entry.next_hop       = item_ff.router_id;
                  rsp_item.status         = STAT_ADDED;
                  rsp_item.slot           = slot_ext[5:0];
                  rsp_item.route_distance = item_ff.distance;
                  rsp_item.route_next_hop = item_ff.router_id;
                  if (ctrl.out_free) begin
                     count_in = count_ff + COUNT_W'(1);
                  end
               end
            end else begin
               rsp_item.slot           = slot_ext[5:0];
               rsp_item.route_distance = hit_ff.distance;
               rsp_item.route_next_hop = hit_ff.next_hop;
               if (item_ff.opcode == OP_LOAD) begin
                  rsp_item.status = STAT_DUPLICATE;
               end else if (hit_ff.next_hop == item_ff.router_id) begin
                  wr_en                   = ctrl.out_free;
                  wr_entry.distance       = item_ff.distance;
                  rsp_item.status         = STAT_REFRESHED;
                  rsp_item.route_distance = item_ff.distance;
               end else if (hit_ff.distance > item_ff.distance) begin
                  wr_en                   = ctrl.out_free;
                  wr_entry.distance       = item_ff.distance;
                  wr_entry.next_hop       = item_ff.router_id;
                  rsp_item.status         = STAT_REROUTED;
                  rsp_item.route_distance = item_ff.distance;
                  rsp_item.route_next_hop = item_ff.router_id;
               end else begin
                  rsp_item.status = STAT_KEPT;
               end
            end
            stat.done = ctrl.out_free;
         end
         default: ;
      endcase
   end

endmodule
